### hw/rtl/pap_pkg.sv
// ----------------------------------------------------------------------------
// pap_pkg
// Shared types and constants of the projected polygon area block.
// ----------------------------------------------------------------------------
package pap_pkg;
	localparam int COORD_W      = 24;
	localparam int NORM_W       = 16;
	localparam int SUM_W        = 56;
	localparam int AREA_W       = 55;
	localparam int MAX_VERTICES = 64;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int DOT_W        = 75;
	localparam int QSQ_W        = 112;
	localparam int ROOT_W       = 56;
	localparam int DIV_N_W      = 90;
	localparam int LEN_W        = 34;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_ZERO  = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_SHORT = 2'd0,
		KIND_TRI   = 2'd1,
		KIND_POLY  = 2'd2
	} kind_t;

	// closed face handed from front to back
	typedef struct packed {
		kind_t                    kind;
		logic signed [SUM_W-1:0]  sx;
		logic signed [SUM_W-1:0]  sy;
		logic signed [SUM_W-1:0]  sz;
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
	} face_t;
endpackage

### hw/rtl/polygon_area_projected.sv
// ----------------------------------------------------------------------------
// polygon_area_projected
// Polygon face area by the 3-D shoelace sum, one vertex word per item.
// ----------------------------------------------------------------------------
// Vertex words are taken one a cycle while a face is open; after the last
// vertex the block closes the sum, then hands the face to a two-entry queue,
// and takes no new vertex until the queue has accepted the face. The back
// end spends twelve multiply steps and a 56-step square root on a triangle
// and adds a 90-step divider on a larger face; faces of a few vertices are
// bound by that back end.
module polygon_area_projected (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [pap_pkg::COORD_W-1:0]  vertex_x,
	input  logic signed [pap_pkg::COORD_W-1:0]  vertex_y,
	input  logic signed [pap_pkg::COORD_W-1:0]  vertex_z,
	input  logic signed [pap_pkg::NORM_W-1:0]   normal_x,
	input  logic signed [pap_pkg::NORM_W-1:0]   normal_y,
	input  logic signed [pap_pkg::NORM_W-1:0]   normal_z,
	input  logic                                last_vertex,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pap_pkg::AREA_W-1:0]          area,
	output logic [1:0]                          status
);
	import pap_pkg::*;

	face_t f_face, q_face;
	logic  f_v, f_r, q_v, q_r;

	pap_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.vx(vertex_x), .vy(vertex_y), .vz(vertex_z),
		.nx(normal_x), .ny(normal_y), .nz(normal_z), .last(last_vertex),
		.face_valid(f_v), .face_ready(f_r), .face(f_face)
	);

	pap_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_v), .wr_ready(f_r), .wr_data(f_face),
		.rd_valid(q_v), .rd_ready(q_r), .rd_data(q_face)
	);

	pap_back u_back (
		.clk(clk), .arst_n(arst_n), .face_valid(q_v), .face_ready(q_r), .face(q_face),
		.out_valid(out_valid), .out_ready(out_ready), .area(area), .status(status)
	);
endmodule

### hw/rtl/pap_front.sv
// ----------------------------------------------------------------------------
// pap_front
// Accumulates cross products of consecutive vertices; closes the face in the
// F_CLOSE state after the last vertex and holds it until the queue takes it.
// ----------------------------------------------------------------------------
module pap_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pap_pkg::COORD_W-1:0]   vx,
	input  logic [pap_pkg::COORD_W-1:0]   vy,
	input  logic [pap_pkg::COORD_W-1:0]   vz,
	input  logic [pap_pkg::NORM_W-1:0]    nx,
	input  logic [pap_pkg::NORM_W-1:0]    ny,
	input  logic [pap_pkg::NORM_W-1:0]    nz,
	input  logic                          last,
	output logic                          face_valid,
	input  logic                          face_ready,
	output pap_pkg::face_t                face
);
	import pap_pkg::*;

	typedef enum logic [1:0] {
		F_ACC   = 2'b01,
		F_CLOSE = 2'b10
	} fstate_t;

	fstate_t                  state_q;
	logic signed [COORD_W-1:0] fx_q, fy_q, fz_q, px_q, py_q, pz_q;
	logic signed [SUM_W-1:0]   sx_q, sy_q, sz_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [NORM_W-1:0]  nx_q, ny_q, nz_q;
	logic                      out_v_q;
	face_t                     face_q;

	logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz;
	logic signed [SUM_W-1:0]   cx, cy, cz;
	logic                      take, hold_v;

	assign in_ready = (state_q == F_ACC) && !out_v_q;
	assign take     = in_valid && in_ready;
	assign hold_v   = cnt_q < CNT_W'(MAX_VERTICES);

	always_comb begin
		ax = px_q; ay = py_q; az = pz_q;
		if (state_q == F_CLOSE) begin
			bx = fx_q; by = fy_q; bz = fz_q;
		end else begin
			bx = vx; by = vy; bz = vz;
		end
		cx = SUM_W'(ay * bz) - SUM_W'(az * by);
		cy = SUM_W'(az * bx) - SUM_W'(ax * bz);
		cz = SUM_W'(ax * by) - SUM_W'(ay * bx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_ACC;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
			px_q <= '0; py_q <= '0; pz_q <= '0;
			fx_q <= '0; fy_q <= '0; fz_q <= '0;
		end else begin
			if (out_v_q && face_ready) out_v_q <= 1'b0;
			case (state_q)
				F_ACC: begin
					if (take) begin
						if (hold_v) begin
							if (cnt_q == '0) begin
								fx_q <= vx; fy_q <= vy; fz_q <= vz;
							end else begin
								sx_q <= sx_q + cx; sy_q <= sy_q + cy; sz_q <= sz_q + cz;
							end
							px_q <= vx; py_q <= vy; pz_q <= vz;
							cnt_q <= cnt_q + 1'b1;
						end
						if (last) begin
							nx_q <= nx; ny_q <= ny; nz_q <= nz;
							state_q <= F_CLOSE;
						end
					end
				end
				F_CLOSE: begin
					face_q.sx <= sx_q + cx;
					face_q.sy <= sy_q + cy;
					face_q.sz <= sz_q + cz;
					face_q.nx <= nx_q; face_q.ny <= ny_q; face_q.nz <= nz_q;
					if (cnt_q < CNT_W'(3))       face_q.kind <= KIND_SHORT;
					else if (cnt_q == CNT_W'(3)) face_q.kind <= KIND_TRI;
					else                         face_q.kind <= KIND_POLY;
					out_v_q <= 1'b1;
					cnt_q   <= '0;
					sx_q <= '0; sy_q <= '0; sz_q <= '0;
					px_q <= '0; py_q <= '0; pz_q <= '0;
					fx_q <= '0; fy_q <= '0; fz_q <= '0;
					state_q <= F_ACC;
				end
				default: state_q <= F_ACC;
			endcase
		end
	end

	assign face_valid = out_v_q;
	assign face       = face_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_VERTICES)) else $error("vertex count overrun");
	a_close_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_CLOSE |=> out_v_q) else $error("closed face not queued");
	a_no_take_close: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_CLOSE |-> !in_ready) else $error("take while closing");
endmodule

### hw/rtl/pap_fifo.sv
// ----------------------------------------------------------------------------
// pap_fifo
// Two-entry queue of closed faces between front and back.
// ----------------------------------------------------------------------------
module pap_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  pap_pkg::face_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output pap_pkg::face_t rd_data
);
	import pap_pkg::*;

	face_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] n_q;
	logic       wr, rd;

	assign wr_ready = n_q != 2'd2;
	assign rd_valid = n_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; n_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			n_q <= n_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 2'd2) else $error("queue count overflow");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q == 2'd0 || n_q == 2'd2) |-> wp_q == rp_q) else $error("queue pointers");
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		wr && !rd |=> n_q == $past(n_q) + 2'd1) else $error("queue count");
endmodule

### hw/rtl/pap_back.sv
// ----------------------------------------------------------------------------
// pap_back
// Final area per face: squared terms over a shared multiplier and a restoring
// square root; larger faces add a restoring divider and saturate the result.
// ----------------------------------------------------------------------------
module pap_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         face_valid,
	output logic                         face_ready,
	input  pap_pkg::face_t               face,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pap_pkg::AREA_W-1:0]   area,
	output logic [1:0]                   status
);
	import pap_pkg::*;

	typedef enum logic [7:0] {
		B_IDLE  = 8'b00000001,
		B_MUL   = 8'b00000010,
		B_SQRT  = 8'b00000100,
		B_DIV   = 8'b00001000,
		B_DONE  = 8'b00010000,
		B_OUT   = 8'b00100000
	} bstate_t;

	bstate_t                 state_q;
	face_t                   f_q;
	logic [1:0]              k_q;
	logic [1:0]              j_q;
	logic [6:0]              it_q;
	logic [QSQ_W-1:0]        q_q;
	logic signed [DOT_W-1:0] d_q;
	logic [33:0]             nn_q;
	logic [ROOT_W-1:0]       r_q;
	logic [ROOT_W+1:0]       rm_q;
	logic [DIV_N_W-1:0]      num_q;
	logic [LEN_W:0]          rem_q;
	logic [AREA_W-1:0]       area_q;
	status_t                 st_q;

	logic [SUM_W-1:0]        mag;
	logic signed [SUM_W-1:0] sk;
	logic signed [NORM_W-1:0] nk;
	logic [27:0]             ma, mb;
	logic [55:0]             prod;
	logic [QSQ_W-1:0]        part;
	logic signed [DOT_W-1:0] dot_term;
	logic [33:0]             nn_term;
	logic [ROOT_W+1:0]       rm_sh;
	logic [ROOT_W+1:0]       rt;
	logic [DOT_W-1:0]        dabs;
	logic [LEN_W:0]          rem_sh;
	logic [LEN_W-1:0]        len;

	always_comb begin
		case (k_q)
			2'd0:    begin sk = f_q.sx; nk = f_q.nx; end
			2'd1:    begin sk = f_q.sy; nk = f_q.ny; end
			default: begin sk = f_q.sz; nk = f_q.nz; end
		endcase
		mag      = sk[SUM_W-1] ? SUM_W'(-sk) : SUM_W'(sk);
		case (j_q)
			2'd0:    begin ma = mag[27:0];  mb = mag[27:0];  end
			2'd3:    begin ma = mag[55:28]; mb = mag[55:28]; end
			default: begin ma = mag[27:0];  mb = mag[55:28]; end
		endcase
		prod     = ma * mb;
		case (j_q)
			2'd0:    part = QSQ_W'(prod);
			2'd3:    part = QSQ_W'(prod) << 56;
			default: part = QSQ_W'(prod) << 28;
		endcase
		dot_term = DOT_W'(sk) * DOT_W'(nk);
		nn_term  = 34'(32'(nk * nk));
		rm_sh    = {rm_q[ROOT_W-1:0], q_q[QSQ_W-1 -: 2]};
		rt       = {r_q, 2'b01};
		dabs     = d_q[DOT_W-1] ? DOT_W'(-d_q) : DOT_W'(d_q);
		len      = LEN_W'(r_q);
		rem_sh   = {rem_q[LEN_W-1:0], num_q[DIV_N_W-1]};
	end

	assign face_ready = state_q == B_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			case (state_q)
				B_IDLE: if (face_valid) begin
					f_q <= face; k_q <= '0; j_q <= '0; q_q <= '0; d_q <= '0; nn_q <= '0;
					r_q <= '0; rm_q <= '0; area_q <= '0;
					if (face.kind == KIND_SHORT) begin
						st_q <= ST_SHORT; state_q <= B_OUT;
					end else begin
						st_q <= ST_OK; state_q <= B_MUL;
					end
				end
				B_MUL: begin
					if (j_q == 2'd0) begin
						d_q  <= d_q + dot_term;
						nn_q <= nn_q + nn_term;
					end
					j_q <= j_q + 2'd1;
					if (j_q == 2'd3 && k_q == 2'd2) begin
						k_q  <= k_q + 2'd1;
						it_q <= 7'd55;
						if (f_q.kind == KIND_POLY) begin
							q_q <= QSQ_W'(nn_q) << 32;
							if (nn_q == '0) begin
								st_q <= ST_ZERO; state_q <= B_OUT;
							end else state_q <= B_SQRT;
						end else begin
							q_q <= q_q + part;
							state_q <= B_SQRT;
						end
					end else begin
						if (j_q == 2'd3) k_q <= k_q + 2'd1;
						q_q <= q_q + part;
					end
				end
				B_SQRT: begin
					if (rm_sh >= rt) begin
						rm_q <= rm_sh - rt;
						r_q  <= {r_q[ROOT_W-2:0], 1'b1};
					end else begin
						rm_q <= rm_sh;
						r_q  <= {r_q[ROOT_W-2:0], 1'b0};
					end
					q_q <= q_q << 2;
					if (it_q == 7'd0) begin
						if (f_q.kind == KIND_TRI) begin
							state_q <= B_DONE;
						end else begin
							num_q <= DIV_N_W'(dabs) << 15;
							rem_q <= '0;
							it_q  <= 7'(DIV_N_W - 1);
							state_q <= B_DIV;
						end
					end else it_q <= it_q - 7'd1;
				end
				B_DIV: begin
					if (rem_sh >= {1'b0, len}) begin
						rem_q <= rem_sh - {1'b0, len};
						if (it_q >= 7'(AREA_W) || area_q[AREA_W-1]) st_q <= ST_SAT;
						area_q <= {area_q[AREA_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						if (area_q[AREA_W-1]) st_q <= ST_SAT;
						area_q <= {area_q[AREA_W-2:0], 1'b0};
					end
					num_q <= {num_q[DIV_N_W-2:0], 1'b0};
					it_q <= it_q - 7'd1;
					if (it_q == 7'd0) state_q <= B_DONE;
				end
				B_DONE: begin
					if (f_q.kind == KIND_TRI) area_q <= AREA_W'(r_q >> 1);
					else if (st_q == ST_SAT) area_q <= '1;
					state_q <= B_OUT;
				end
				B_OUT: if (out_ready) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid = state_q == B_OUT;
	assign area      = area_q;
	assign status    = st_q;

	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && st_q == ST_SHORT |-> area_q == '0) else $error("short area");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && st_q == ST_ZERO |-> area_q == '0) else $error("zero normal area");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && st_q == ST_SAT |-> area_q == '1) else $error("saturation value");
endmodule

### test/pap_checker.sv
// ----------------------------------------------------------------------------
// pap_checker
// Watches both channels of polygon_area_projected, predicts the area word
// of every closed face and compares it field by field on the result side.
// ----------------------------------------------------------------------------
module pap_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [pap_pkg::COORD_W-1:0]  vertex_x,
	input  logic signed [pap_pkg::COORD_W-1:0]  vertex_y,
	input  logic signed [pap_pkg::COORD_W-1:0]  vertex_z,
	input  logic signed [pap_pkg::NORM_W-1:0]   normal_x,
	input  logic signed [pap_pkg::NORM_W-1:0]   normal_y,
	input  logic signed [pap_pkg::NORM_W-1:0]   normal_z,
	input  logic                                last_vertex,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [pap_pkg::AREA_W-1:0]          area,
	input  logic [1:0]                          status,
	output int                                  errors,
	output int                                  pending,
	output int                                  faces_checked
);
	import pap_pkg::*;

	localparam logic [AREA_W-1:0] AREA_MAX = '1;

	typedef struct packed {
		logic [AREA_W-1:0] area;
		status_t           status;
	} area_word_t;

	logic signed [SUM_W-1:0] first_v [3];
	logic signed [SUM_W-1:0] prev_v [3];
	logic signed [SUM_W-1:0] sum_v [3];
	int unsigned             held;
	area_word_t              area_q [$];

	assign pending = area_q.size();

	function automatic logic [63:0] isqrt128(input logic [127:0] q);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if ({64'd0, t} * {64'd0, t} <= q)
				r = t;
		end
		return r;
	endfunction

	function automatic void add_cross(input logic signed [SUM_W-1:0] a [3],
			input logic signed [SUM_W-1:0] b [3]);
		sum_v[0] = sum_v[0] + a[1] * b[2] - a[2] * b[1];
		sum_v[1] = sum_v[1] + a[2] * b[0] - a[0] * b[2];
		sum_v[2] = sum_v[2] + a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic area_word_t close_face(input logic signed [NORM_W-1:0] nx,
			input logic signed [NORM_W-1:0] ny, input logic signed [NORM_W-1:0] nz);
		area_word_t w;
		logic signed [127:0] s0, s1, s2, n0, n1, n2, d;
		logic [127:0] ud, nn, quot;
		logic [63:0] len;
		s0 = sum_v[0];
		s1 = sum_v[1];
		s2 = sum_v[2];
		n0 = nx;
		n1 = ny;
		n2 = nz;
		w.area = '0;
		w.status = ST_OK;
		if (held < 3) begin
			w.status = ST_SHORT;
		end else if (held == 3) begin
			ud = isqrt128(s0 * s0 + s1 * s1 + s2 * s2) >> 1;
			if (ud > AREA_MAX) begin
				w.area = AREA_MAX;
				w.status = ST_SAT;
			end else begin
				w.area = ud[AREA_W-1:0];
			end
		end else begin
			nn = n0 * n0 + n1 * n1 + n2 * n2;
			if (nn == 0) begin
				w.status = ST_ZERO;
			end else begin
				d = s0 * n0 + s1 * n1 + s2 * n2;
				ud = (d < 0) ? -d : d;
				len = isqrt128(nn << 32);
				if ((ud >> 113) != 0) begin
					w.area = AREA_MAX;
					w.status = ST_SAT;
				end else begin
					quot = (ud << 15) / {64'd0, len};
					if (quot > AREA_MAX) begin
						w.area = AREA_MAX;
						w.status = ST_SAT;
					end else begin
						w.area = quot[AREA_W-1:0];
					end
				end
			end
		end
		return w;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		area_word_t want;
		logic signed [SUM_W-1:0] v [3];
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				first_v[k] = '0;
				prev_v[k] = '0;
				sum_v[k] = '0;
			end
			held = 0;
			area_q.delete();
			errors = 0;
			faces_checked = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (held < MAX_VERTICES) begin
					v[0] = vertex_x;
					v[1] = vertex_y;
					v[2] = vertex_z;
					if (held == 0)
						first_v = v;
					else
						add_cross(prev_v, v);
					prev_v = v;
					held++;
				end
				if (last_vertex) begin
					add_cross(prev_v, first_v);
					area_q = {area_q, close_face(normal_x, normal_y, normal_z)};
					for (int k = 0; k < 3; k++) begin
						first_v[k] = '0;
						prev_v[k] = '0;
						sum_v[k] = '0;
					end
					held = 0;
				end
			end
			if (out_valid && out_ready) begin
				if (area_q.size() == 0) begin
					report("unexpected word", area, 0);
				end else begin
					want = area_q.pop_front();
					if (area !== want.area)
						report("area", area, want.area);
					if (status !== want.status)
						report("status", status, want.status);
					faces_checked++;
				end
			end
		end
	end
endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives vertex words into polygon_area_projected: directed faces covering
// short faces, triangles, zero normals and overlong faces, then random
// faces under several idle and stall mixes; pap_checker judges results.
// ----------------------------------------------------------------------------
module tb;
	import pap_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [COORD_W-1:0] vertex_x, vertex_y, vertex_z;
	logic signed [NORM_W-1:0]  normal_x, normal_y, normal_z;
	logic last_vertex;
	logic out_valid;
	logic out_ready;
	logic [AREA_W-1:0] area;
	logic [1:0] status;
	int errors, pending, faces_checked;
	int send_idle, recv_stall;
	int words_sent;
	bit hold_req;
	bit done;

	polygon_area_projected i_dut (.*);

	pap_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("Timeout after %0d quiet cycles", quiet);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_ready <= arst_n && ($urandom_range(99) >= recv_stall);
		end
	end

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(3))
			0: return COORD_W'($urandom);
			1: return COORD_W'(int'($urandom_range(4095)) - 2048);
			2: return $urandom_range(1) ? {1'b0, {(COORD_W-1){1'b1}}}
				: {1'b1, {(COORD_W-1){1'b0}}};
			default: return COORD_W'($urandom);
		endcase
	endfunction

	task automatic send(input logic signed [COORD_W-1:0] x, y, z,
			input logic signed [NORM_W-1:0] nx, ny, nz, input logic last);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		vertex_x <= x;
		vertex_y <= y;
		vertex_z <= z;
		normal_x <= nx;
		normal_y <= ny;
		normal_z <= nz;
		last_vertex <= last;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic send_face(input int verts, input int norm_kind);
		logic signed [NORM_W-1:0] nx, ny, nz;
		nx = NORM_W'($urandom);
		ny = NORM_W'($urandom);
		nz = NORM_W'($urandom);
		if (norm_kind == 1) begin
			nx = '0;
			ny = '0;
			nz = '0;
		end else if (norm_kind == 2) begin
			nx = {1'b1, {(NORM_W-1){1'b0}}};
			ny = {1'b0, {(NORM_W-1){1'b1}}};
			nz = {1'b1, {(NORM_W-1){1'b0}}};
		end
		for (int i = 0; i < verts; i++)
			send(rand_coord(), rand_coord(), rand_coord(),
				NORM_W'($urandom), NORM_W'($urandom), NORM_W'($urandom), 1'b0);
		send(rand_coord(), rand_coord(), rand_coord(), nx, ny, nz, 1'b1);
	endtask

	initial begin
		int faces;
		logic signed [COORD_W-1:0] hi, lo;
		hi = {1'b0, {(COORD_W-1){1'b1}}};
		lo = {1'b1, {(COORD_W-1){1'b0}}};
		arst_n = 1'b0;
		in_valid = 1'b0;
		vertex_x = '0;
		vertex_y = '0;
		vertex_z = '0;
		normal_x = '0;
		normal_y = '0;
		normal_z = '0;
		last_vertex = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		hold_req = 1'b0;
		words_sent = 0;
		faces = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short faces, an extreme triangle, zero and extreme normals
		send(hi, lo, hi, 0, 0, 0, 1'b1);
		send(lo, lo, lo, 0, 0, 0, 1'b0);
		send(hi, hi, hi, 0, 0, 0, 1'b1);
		send(hi, lo, 0, 0, 0, 0, 1'b0);
		send(lo, hi, hi, 0, 0, 0, 1'b0);
		send(0, hi, lo, 0, 0, 0, 1'b1);
		send(hi, 0, 0, 0, 0, 0, 1'b0);
		send(0, hi, 0, 0, 0, 0, 1'b0);
		send(0, 0, lo, 0, 0, 0, 1'b0);
		send(lo, lo, hi, 0, 0, 0, 1'b1);
		send_face(3, 2);
		send_face(4, 0);
		send_face(5, 2);
		send_face(69, 0);
		faces = 8;

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 66; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 66; end
				3: begin send_idle = 27; recv_stall = 27; end
				default: begin send_idle = 0; recv_stall = 10; hold_req = 1'b1; end
			endcase
			while (words_sent < 350 * (ph + 1)) begin
				case ($urandom_range(19))
					0: send_face($urandom_range(1), $urandom_range(2));
					1: send_face($urandom_range(63, 70), 0);
					2: send_face($urandom_range(3, 6), 1);
					3, 4, 5, 6: send_face(2, 0);
					default: send_face($urandom_range(3, 7), $urandom_range(9) == 0 ? 2 : 0);
				endcase
				faces++;
			end
		end
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d vertex words in %0d faces; %0d area words checked",
			words_sent, faces, faces_checked);
		$display("Phases: no idling, sender idle, receiver stall, both, long hold-off");
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
